@@ design/ffba_pkg.sv @@
// Package for the first-fit block allocator.
// Holds default sizes, request codes, field widths and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int unsigned MEM_BYTES_DEF    = 1048576;
    localparam int unsigned PAGE_BYTES_DEF   = 4096;
    localparam int unsigned HEADER_BYTES_DEF = 32;
    localparam int unsigned MAX_BLOCKS_DEF   = 64;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PID_W   = 16;
    localparam int unsigned FREE_W  = 21;
    localparam int unsigned PADDR_W = 2;

    localparam logic [ADDR_W-1:0]  REGION_BASE_RESET = 32'h0005_0000;
    localparam logic [PADDR_W-1:0] REG_REGION_BASE   = 2'd0;

    typedef enum logic [1:0] {
        ACT_ALLOC      = 2'd0,
        ACT_FREE_ADDR  = 2'd1,
        ACT_FREE_OWNER = 2'd2,
        ACT_NOP        = 2'd3
    } action_t;

    typedef enum logic [11:0] {
        S_INIT      = 12'b0000_0000_0001,
        S_IDLE      = 12'b0000_0000_0010,
        S_DIV       = 12'b0000_0000_0100,
        S_SCAN_RD   = 12'b0000_0000_1000,
        S_SCAN_CHK  = 12'b0000_0001_0000,
        S_SHIFT_RD  = 12'b0000_0010_0000,
        S_SHIFT_WR  = 12'b0000_0100_0000,
        S_SPLIT_WR  = 12'b0000_1000_0000,
        S_GRANT     = 12'b0001_0000_0000,
        S_FREE_RD   = 12'b0010_0000_0000,
        S_FREE_CHK  = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } state_t;

endpackage

@@ design/ffba_table_ram.sv @@
// Block table storage for the first-fit block allocator.
// One write port and one registered read port. Depends on nothing.
`timescale 1ns / 1ps

module ffba_table_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 59
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/first_fit_block_allocator.sv @@
// First-fit block allocator: top level with request sequencer and APB register.
// Depends on ffba_pkg and ffba_table_ram.
//
// The block keeps an address-ordered table of blocks in a RAM with one write port and
// a registered read port, and every allocate or free walks it one entry at a time.
// After reset S_INIT writes the initial free block before the first request is
// taken. Allocate: S_IDLE takes the request and S_DIV sizes it in pages (a reciprocal
// multiply for the page count, plus one page, then a multiply back); the scan then
// reads entries up to the fitting block, a split moves each entry above it up,
// S_SPLIT_WR writes the split-off tail when there is one, S_GRANT writes the granted
// entry and S_DONE hands over the result once the result register is free. An
// allocate rejected on size and a no-op go straight to S_DONE. Free and free-all
// mark and merge in one pass. One request is in work at a time.
`timescale 1ns / 1ps

module first_fit_block_allocator #(
    parameter int unsigned MEM_BYTES    = ffba_pkg::MEM_BYTES_DEF,
    parameter int unsigned PAGE_BYTES   = ffba_pkg::PAGE_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int unsigned MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_action,
    input  logic [ffba_pkg::ADDR_W-1:0]   s_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]   s_address,
    input  logic [ffba_pkg::PID_W-1:0]    s_owner_pid,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ffba_pkg::ADDR_W-1:0]   m_result_address,
    output logic                          m_success,
    output logic [ffba_pkg::FREE_W-1:0]   m_free_bytes,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffba_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned SZ    = $clog2(MEM_BYTES + 1);
    localparam int unsigned PW    = $clog2(MEM_BYTES + PAGE_BYTES + 1);
    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned OWN_W = ffba_pkg::PID_W;
    localparam int unsigned ENT_W = 2 * SZ + 1 + OWN_W;
    localparam int unsigned AW    = ffba_pkg::ADDR_W;
    localparam int unsigned FW    = ffba_pkg::FREE_W;
    localparam int unsigned RC_SH = SZ + $clog2(PAGE_BYTES);

    localparam longint unsigned RECIP = ((64'd1 << RC_SH) + 64'(PAGE_BYTES) - 64'd1) /
                                        64'(PAGE_BYTES);

    localparam logic [SZ-1:0]    INIT_SIZE = SZ'(MEM_BYTES - HEADER_BYTES);
    localparam logic [SZ:0]      HDR_SZ    = (SZ+1)'(HEADER_BYTES);
    localparam logic [PW:0]      HDR_PW    = (PW+1)'(HEADER_BYTES);
    localparam logic [PW-1:0]    PAGE_PW   = PW'(PAGE_BYTES);
    localparam logic [SZ+1:0]    RECIP_C   = (SZ+2)'(RECIP);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_BLOCKS);

    ffba_pkg::state_t state_reg, state_next;

    logic [AW-1:0]       base_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SZ-1:0]       ft_reg, ft_next;
    logic [1:0]          act_reg;
    logic [AW-1:0]       size_reg, addr_reg;
    logic [OWN_W-1:0]    pid_reg;
    logic                div_cnt_reg, div_cnt_next;
    logic [PW-1:0]       pages_reg, pages_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    w_reg, w_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [ENT_W-1:0]    hit_reg, hit_next;
    logic                split_reg, split_next;
    logic [ENT_W-1:0]    cur_reg, cur_next;
    logic                have_cur_reg, have_cur_next;
    logic                ok_reg, ok_next;
    logic [SZ-1:0]       sum_reg, sum_next;
    logic [AW-1:0]       res_addr_reg, res_addr_next;

    logic                m_valid_reg;
    logic [AW-1:0]       m_result_address_reg;
    logic                m_success_reg;
    logic [FW-1:0]       m_free_bytes_reg;

    // table port
    logic                we, re;
    logic [IDX_W-1:0]    waddr, raddr;
    logic [ENT_W-1:0]    wdata, rdata;

    ffba_table_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(ENT_W)) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // entry fields of the read data, the held hit and the open run
    logic [SZ-1:0]    e_off, e_size, h_off, h_size, c_size;
    logic             e_free, c_free;
    logic [OWN_W-1:0] e_own;
    assign e_off  = rdata[ENT_W-1 -: SZ];
    assign e_size = rdata[ENT_W-1-SZ -: SZ];
    assign e_free = rdata[OWN_W];
    assign e_own  = rdata[OWN_W-1:0];
    assign h_off  = hit_reg[ENT_W-1 -: SZ];
    assign h_size = hit_reg[ENT_W-1-SZ -: SZ];
    assign c_size = cur_reg[ENT_W-1-SZ -: SZ];
    assign c_free = cur_reg[OWN_W];

    logic [AW-1:0]   e_payload;
    logic [2*SZ+1:0] quo_prod;
    logic [PW:0]     need_split;
    logic            e_fits, e_match;
    logic [SZ:0]     merged_size, sum_add;
    logic [PW:0]     grant_ft;
    logic [FW+SZ-1:0] free_ext;

    assign e_payload  = base_reg + AW'(e_off) + AW'(HEADER_BYTES);
    assign quo_prod   = (2*SZ+2)'(size_reg[SZ-1:0]) * (2*SZ+2)'(RECIP_C);
    assign need_split = {1'b0, pages_reg} + HDR_PW;
    assign e_fits     = e_free && ((PW+1)'(e_size) >= {1'b0, pages_reg});
    assign e_match    = !e_free && ((act_reg == ffba_pkg::ACT_FREE_ADDR) ?
                        (e_payload == addr_reg) : (e_own == pid_reg));
    assign merged_size = (SZ+1)'(c_size) + HDR_SZ + (SZ+1)'(e_size);
    assign sum_add    = (SZ+1)'(sum_reg) + (c_free ? (SZ+1)'(c_size) : '0);
    assign grant_ft   = split_reg ? ((PW+1)'(ft_reg) - {1'b0, pages_reg} - HDR_PW)
                                  : ((PW+1)'(ft_reg) - (PW+1)'(h_size));
    assign free_ext   = {{FW{1'b0}}, ft_reg};

    assign s_ready = (state_reg == ffba_pkg::S_IDLE);
    assign pready  = 1'b1;
    assign prdata  = (paddr == ffba_pkg::REG_REGION_BASE) ? base_reg : '0;

    assign m_valid          = m_valid_reg;
    assign m_result_address = m_result_address_reg;
    assign m_success        = m_success_reg;
    assign m_free_bytes     = m_free_bytes_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ft_next       = ft_reg;
        div_cnt_next  = div_cnt_reg;
        pages_next    = pages_reg;
        idx_next      = idx_reg;
        w_next        = w_reg;
        hit_idx_next  = hit_idx_reg;
        hit_next      = hit_reg;
        split_next    = split_reg;
        cur_next      = cur_reg;
        have_cur_next = have_cur_reg;
        ok_next       = ok_reg;
        sum_next      = sum_reg;
        res_addr_next = res_addr_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        re    = 1'b0;
        raddr = '0;

        case (state_reg)
            ffba_pkg::S_INIT: begin
                we         = 1'b1;
                wdata      = {SZ'(0), INIT_SIZE, 1'b1, OWN_W'(0)};
                cnt_next   = CNT_W'(1);
                ft_next    = INIT_SIZE;
                state_next = ffba_pkg::S_IDLE;
            end
            ffba_pkg::S_IDLE: begin
                ok_next       = 1'b0;
                res_addr_next = '0;
                idx_next      = '0;
                w_next        = '0;
                have_cur_next = 1'b0;
                sum_next      = '0;
                div_cnt_next  = 1'b0;
                if (s_valid) begin
                    case (s_action)
                        ffba_pkg::ACT_ALLOC: begin
                            if (s_request_size > AW'(MEM_BYTES) ||
                                s_request_size >= AW'(ft_reg)) begin
                                state_next = ffba_pkg::S_DONE;
                            end else begin
                                state_next = ffba_pkg::S_DIV;
                            end
                        end
                        ffba_pkg::ACT_FREE_ADDR, ffba_pkg::ACT_FREE_OWNER: begin
                            state_next = ffba_pkg::S_FREE_RD;
                        end
                        default: begin
                            state_next = ffba_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ffba_pkg::S_DIV: begin
                if (!div_cnt_reg) begin
                    // page count by reciprocal multiply, exact for any size up to the region
                    pages_next   = PW'(quo_prod >> RC_SH);
                    div_cnt_next = 1'b1;
                end else begin
                    pages_next = (pages_reg + PW'(1)) * PAGE_PW;
                    state_next = ffba_pkg::S_SCAN_RD;
                end
            end
            ffba_pkg::S_SCAN_RD: begin
                if (idx_reg == cnt_reg) begin
                    state_next = ffba_pkg::S_DONE;
                end else begin
                    re         = 1'b1;
                    raddr      = idx_reg[IDX_W-1:0];
                    state_next = ffba_pkg::S_SCAN_CHK;
                end
            end
            ffba_pkg::S_SCAN_CHK: begin
                if (e_fits) begin
                    hit_next     = rdata;
                    hit_idx_next = idx_reg[IDX_W-1:0];
                    split_next   = ((PW+1)'(e_size) >= need_split) && (cnt_reg < MAX_CNT);
                    idx_next     = cnt_reg;
                    if (!((PW+1)'(e_size) >= need_split) || !(cnt_reg < MAX_CNT)) begin
                        state_next = ffba_pkg::S_GRANT;
                    end else if (cnt_reg > (CNT_W'(idx_reg) + CNT_W'(1))) begin
                        state_next = ffba_pkg::S_SHIFT_RD;
                    end else begin
                        state_next = ffba_pkg::S_SPLIT_WR;
                    end
                end else begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ffba_pkg::S_SCAN_RD;
                end
            end
            ffba_pkg::S_SHIFT_RD: begin
                re         = 1'b1;
                raddr      = IDX_W'(idx_reg - CNT_W'(1));
                state_next = ffba_pkg::S_SHIFT_WR;
            end
            ffba_pkg::S_SHIFT_WR: begin
                // move one entry up, walking down from the top
                we       = 1'b1;
                waddr    = idx_reg[IDX_W-1:0];
                wdata    = rdata;
                idx_next = idx_reg - CNT_W'(1);
                if (idx_next > (CNT_W'(hit_idx_reg) + CNT_W'(1))) begin
                    state_next = ffba_pkg::S_SHIFT_RD;
                end else begin
                    state_next = ffba_pkg::S_SPLIT_WR;
                end
            end
            ffba_pkg::S_SPLIT_WR: begin
                we    = 1'b1;
                waddr = hit_idx_reg + IDX_W'(1);
                wdata = {SZ'((PW+1)'(h_off) + need_split),
                         SZ'((PW+1)'(h_size) - need_split),
                         1'b1, OWN_W'(0)};
                state_next = ffba_pkg::S_GRANT;
            end
            ffba_pkg::S_GRANT: begin
                we    = 1'b1;
                waddr = hit_idx_reg;
                wdata = {h_off, split_reg ? SZ'(pages_reg) : h_size, 1'b0, pid_reg};
                if (split_reg) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                ft_next       = SZ'(grant_ft);
                ok_next       = 1'b1;
                res_addr_next = base_reg + AW'(h_off) + AW'(HEADER_BYTES);
                state_next    = ffba_pkg::S_DONE;
            end
            ffba_pkg::S_FREE_RD: begin
                if (idx_reg == cnt_reg) begin
                    // flush the last run and close the table
                    we         = 1'b1;
                    waddr      = w_reg;
                    wdata      = cur_reg;
                    cnt_next   = CNT_W'(w_reg) + CNT_W'(1);
                    ft_next    = SZ'(sum_add);
                    state_next = ffba_pkg::S_DONE;
                end else begin
                    re         = 1'b1;
                    raddr      = idx_reg[IDX_W-1:0];
                    state_next = ffba_pkg::S_FREE_CHK;
                end
            end
            ffba_pkg::S_FREE_CHK: begin
                cur_next = rdata;
                if (e_match) begin
                    cur_next[OWN_W]         = 1'b1;
                    cur_next[OWN_W-1:0]     = '0;
                    ok_next                 = 1'b1;
                end
                if (have_cur_reg && c_free && (e_free || e_match)) begin
                    // merge into the open run, taking in the header between
                    cur_next = cur_reg;
                    cur_next[ENT_W-1-SZ -: SZ] = SZ'(merged_size);
                end else if (have_cur_reg) begin
                    we       = 1'b1;
                    waddr    = w_reg;
                    wdata    = cur_reg;
                    w_next   = w_reg + IDX_W'(1);
                    sum_next = SZ'(sum_add);
                end
                have_cur_next = 1'b1;
                idx_next      = idx_reg + CNT_W'(1);
                state_next    = ffba_pkg::S_FREE_RD;
            end
            ffba_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffba_pkg::S_INIT;
            base_reg    <= ffba_pkg::REGION_BASE_RESET;
            cnt_reg     <= CNT_W'(1);
            ft_reg      <= INIT_SIZE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ft_reg    <= ft_next;
            if (psel && penable && pwrite && pready &&
                paddr == ffba_pkg::REG_REGION_BASE) begin
                base_reg <= pwdata;
            end
            if (state_reg == ffba_pkg::S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ffba_pkg::S_IDLE && s_valid) begin
            act_reg  <= s_action;
            size_reg <= s_request_size;
            addr_reg <= s_address;
            pid_reg  <= s_owner_pid;
        end
        div_cnt_reg  <= div_cnt_next;
        pages_reg    <= pages_next;
        idx_reg      <= idx_next;
        w_reg        <= w_next;
        hit_idx_reg  <= hit_idx_next;
        hit_reg      <= hit_next;
        split_reg    <= split_next;
        cur_reg      <= cur_next;
        have_cur_reg <= have_cur_next;
        ok_reg       <= ok_next;
        sum_reg      <= sum_next;
        res_addr_reg <= res_addr_next;
        if (state_reg == ffba_pkg::S_DONE && (!m_valid_reg || m_ready)) begin
            m_result_address_reg <= res_addr_reg;
            m_success_reg        <= ok_reg;
            m_free_bytes_reg     <= free_ext[FW-1:0];
        end
    end

    // table never empties and never overflows once initialized
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ffba_pkg::S_INIT) |-> (cnt_reg >= CNT_W'(1) && cnt_reg <= MAX_CNT))
        else $error("block count out of range");

    // free bytes can never exceed one block spanning the whole region
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ft_reg <= INIT_SIZE)
        else $error("free byte total exceeds region");

    // moves stay strictly above the entry being split
    a_shift_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ffba_pkg::S_SHIFT_RD) |->
            (idx_reg > (CNT_W'(hit_idx_reg) + CNT_W'(1))))
        else $error("table shift crossed the split entry");

    // a result is only loaded while the result register can take it
    a_done_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ffba_pkg::S_DONE && m_valid_reg && !m_ready) |=>
            (state_reg == ffba_pkg::S_DONE))
        else $error("result dropped while output stalled");

endmodule
